// ===== design/swks_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swks_pkg : shared types and constants of the sliding window KS detector
// Widths, threshold factors and the token and control words that pass along
// the row of compare cells.
// ----------------------------------------------------------------------------
package swks_pkg;

  // field widths
  localparam int unsigned SampleW = 32;
  localparam int unsigned HwW     = 7;
  localparam int unsigned KsW     = 7;
  localparam int unsigned DiffW   = 8;   // signed count difference, -64..64
  localparam int unsigned CntW    = 8;   // up to twice the largest half window

  // largest half window the register can ask for
  localparam int unsigned MaxHalf = 64;

  // default window capacity
  localparam int unsigned DefCapacity = 128;

  // half window after reset
  localparam logic [HwW-1:0] HwReset = 7'd32;

  // drift test 10000*k^2 > 18496*r, both sides divided by 16
  localparam int unsigned SqW  = 13;
  localparam int unsigned ThrW = 22;
  localparam logic [ThrW-1:0] ThrSqMul = 22'd625;
  localparam logic [ThrW-1:0] ThrHwMul = 22'd1156;

  // one candidate value travelling down the row
  typedef struct packed {
    logic                      valid;
    logic                      last;
    logic signed [SampleW-1:0] key;
    logic signed [DiffW-1:0]   diff;
  } swks_tok_t;

  // per-cycle commands to every cell
  typedef struct packed {
    logic load;        // new word accepted: window shifts, candidates reload
    logic cand_shift;  // candidate line moves one place towards the head
  } swks_ctl_t;

endpackage : swks_pkg
`default_nettype wire

// ===== design/sliding_window_ks_drift_detector_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_ks_drift_detector_unit : two-sample KS drift detector
// Keeps the newest samples in a row of cells and compares the newest
// half_window samples with the half_window before them.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid_i/in_ready_o carries one sample_i word (signed
//    Q16.16). Output channel out_valid_o/out_ready_i returns one result word
//    per sample: drift_detected_o, ks_count_o, window_ready_o.
//  - Config channel cfg_valid_i/cfg_ready_o writes half_window (1..64); it is
//    always ready and must only be written while the unit is idle.
//  - While fewer than 2*half_window samples are held, the result (all zero)
//    is registered via state ST_DONE, and in_ready_o is back with it.
//  - Otherwise every one of the 2*half_window candidates is injected, one per
//    cycle, into a token pipe of DEPTH = min(WindowCapacity, 128) cells. The
//    result is registered once the last token has left the tail and states
//    ST_SQUARE, ST_COMPARE and ST_DONE have passed, and in_ready_o rises with
//    it, so no new sample is taken before the last one is through. The pipe
//    length thus bounds the rate at which samples are taken.
//  - The output register decouples the two sides: a new sample is taken while
//    a result still waits; a further result waits in the unit until the
//    receiver drains the register.
//  - Reset empties the window and sets half_window to 32. The sample storage
//    itself is not cleared; the fill count keeps unwritten cells out of use.
// ----------------------------------------------------------------------------
module sliding_window_ks_drift_detector_unit #(
  parameter int unsigned WindowCapacity = swks_pkg::DefCapacity
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [swks_pkg::HwW-1:0]            cfg_half_window_i,
  // sample input
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [swks_pkg::SampleW-1:0] sample_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                drift_detected_o,
  output logic [swks_pkg::KsW-1:0]            ks_count_o,
  output logic                                window_ready_o
);
  import swks_pkg::*;

  // only the newest 2*MaxHalf samples can ever be compared
  localparam int unsigned Depth  = (WindowCapacity < 2 * MaxHalf) ?
                                   WindowCapacity : 2 * MaxHalf;
  localparam int unsigned FillW  = $clog2(WindowCapacity + 1);
  localparam int unsigned CmpW   = (FillW > CntW) ? FillW : CntW;
  localparam logic [FillW-1:0] FillMax = FillW'(WindowCapacity);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_SQUARE,
    ST_COMPARE,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [HwW-1:0]      hw_q;
  logic [FillW-1:0]    fill_q;
  logic [FillW-1:0]    fill_d;
  logic [CntW-1:0]     inj_cnt_q;
  logic [KsW-1:0]      best_q;
  logic [KsW-1:0]      best_d;
  logic [SqW-1:0]      sq_q;
  logic                drift_q;
  logic                ready_flag_q;
  logic                out_valid_q;
  logic                out_drift_q;
  logic [KsW-1:0]      out_ks_q;
  logic                out_ready_flag_q;

  logic                accept;
  logic                ready_now;
  logic                inject;
  logic [CntW-1:0]     twice_r;
  logic [DiffW-1:0]    abs_diff;
  logic [ThrW-1:0]     thr_lhs;
  logic [ThrW-1:0]     thr_rhs;
  swks_ctl_t           ctl;
  swks_tok_t           inj_tok;
  swks_tok_t           tail_tok;

  logic signed [SampleW-1:0] samp_w [Depth];
  logic signed [SampleW-1:0] cand_w [Depth];
  swks_tok_t                 tok_w  [Depth];

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= HwReset;
    end else if (cfg_valid_i) begin
      hw_q <= cfg_half_window_i;
    end
  end

  // handshake and fill bookkeeping
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign twice_r    = {hw_q, 1'b0};
  assign fill_d     = (fill_q == FillMax) ? fill_q : fill_q + FillW'(1);
  assign ready_now  = (hw_q != '0) && (CmpW'(fill_d) >= CmpW'(twice_r));

  // candidate injection at the head of the row
  assign inject  = (state_q == ST_RUN) && (inj_cnt_q < twice_r);
  assign inj_tok = '{valid: inject, last: (inj_cnt_q == twice_r - CntW'(1)),
                     key: cand_w[0], diff: '0};
  assign ctl     = '{load: accept, cand_shift: inject};

  // row of cells
  for (genvar k = 0; k < Depth; k++) begin : g_cell
    logic signed [SampleW-1:0] s_in;
    logic signed [SampleW-1:0] c_in;
    swks_tok_t                 t_in;

    if (k == 0) begin : g_head
      assign s_in = sample_i;
      assign t_in = inj_tok;
    end else begin : g_body
      assign s_in = samp_w[k-1];
      assign t_in = tok_w[k-1];
    end

    if (k == Depth - 1) begin : g_tail
      assign c_in = '0;
    end else begin : g_mid
      assign c_in = cand_w[k+1];
    end

    swks_cell #(
      .Index(k)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .half_window_i(hw_q),
      .sample_i     (s_in),
      .sample_o     (samp_w[k]),
      .cand_i       (c_in),
      .cand_o       (cand_w[k]),
      .tok_i        (t_in),
      .tok_o        (tok_w[k])
    );
  end

  // running maximum of |difference| at the tail
  assign tail_tok = tok_w[Depth-1];
  assign abs_diff = tail_tok.diff[DiffW-1] ? DiffW'(-tail_tok.diff) : tail_tok.diff;
  assign best_d   = (abs_diff[KsW-1:0] > best_q) ? abs_diff[KsW-1:0] : best_q;

  // threshold sides, after the squaring register
  assign thr_lhs = ThrW'(sq_q) * ThrSqMul;
  assign thr_rhs = ThrW'(hw_q) * ThrHwMul;

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      fill_q           <= '0;
      inj_cnt_q        <= '0;
      best_q           <= '0;
      sq_q             <= '0;
      drift_q          <= 1'b0;
      ready_flag_q     <= 1'b0;
      out_valid_q      <= 1'b0;
      out_drift_q      <= 1'b0;
      out_ks_q         <= '0;
      out_ready_flag_q <= 1'b0;
    end else begin
      // drained result word; in ST_DONE the reload below decides instead
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            fill_q       <= fill_d;
            inj_cnt_q    <= '0;
            best_q       <= '0;
            drift_q      <= 1'b0;
            ready_flag_q <= ready_now;
            state_q      <= ready_now ? ST_RUN : ST_DONE;
          end
        end
        ST_RUN: begin
          if (inject) begin
            inj_cnt_q <= inj_cnt_q + CntW'(1);
          end
          if (tail_tok.valid) begin
            best_q <= best_d;
            if (tail_tok.last) begin
              state_q <= ST_SQUARE;
            end
          end
        end
        ST_SQUARE: begin
          sq_q    <= SqW'(best_q) * SqW'(best_q);
          state_q <= ST_COMPARE;
        end
        ST_COMPARE: begin
          drift_q <= thr_lhs > thr_rhs;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q      <= 1'b1;
            out_drift_q      <= ready_flag_q && drift_q;
            out_ks_q         <= ready_flag_q ? best_q : '0;
            out_ready_flag_q <= ready_flag_q;
            state_q          <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drift_detected_o = out_drift_q;
  assign ks_count_o       = out_ks_q;
  assign window_ready_o   = out_ready_flag_q;

endmodule : sliding_window_ks_drift_detector_unit
`default_nettype wire

// ===== design/swks_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swks_cell : one place of the sample window
// Holds the sample of one age, a copy of it on the candidate line, and one
// stage of the token pipe that counts samples at or below a candidate key.
// ----------------------------------------------------------------------------
module swks_cell #(
  parameter int unsigned Index = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  swks_pkg::swks_ctl_t                ctl_i,
  input  logic [swks_pkg::HwW-1:0]           half_window_i,
  input  logic signed [swks_pkg::SampleW-1:0] sample_i,
  output logic signed [swks_pkg::SampleW-1:0] sample_o,
  input  logic signed [swks_pkg::SampleW-1:0] cand_i,
  output logic signed [swks_pkg::SampleW-1:0] cand_o,
  input  swks_pkg::swks_tok_t                tok_i,
  output swks_pkg::swks_tok_t                tok_o
);
  import swks_pkg::*;

  localparam logic [CntW-1:0] Age = CntW'(Index);

  logic signed [SampleW-1:0] sample_q;
  logic signed [SampleW-1:0] cand_q;
  logic                      tok_valid_q;
  logic                      tok_last_q;
  logic signed [SampleW-1:0] tok_key_q;
  logic signed [DiffW-1:0]   tok_diff_q;
  logic                      in_new;
  logic                      in_old;
  logic                      hit;
  logic signed [DiffW-1:0]   diff_d;

  // which compared half this age falls in
  assign in_new = Age < {1'b0, half_window_i};
  assign in_old = !in_new && (Age < {half_window_i, 1'b0});
  assign hit    = sample_q <= tok_i.key;

  // older half counts up, newer half counts down
  always_comb begin
    diff_d = tok_i.diff;
    if (hit && in_old) begin
      diff_d = tok_i.diff + DiffW'(1);
    end else if (hit && in_new) begin
      diff_d = tok_i.diff - DiffW'(1);
    end
  end

  // window and candidate line
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      sample_q <= sample_i;
      cand_q   <= sample_i;
    end else if (ctl_i.cand_shift) begin
      cand_q   <= cand_i;
    end
  end

  // token stage, valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_i.valid;
    end
  end

  // token stage, payload
  always_ff @(posedge clk_i) begin
    tok_last_q <= tok_i.last;
    tok_key_q  <= tok_i.key;
    tok_diff_q <= diff_d;
  end

  assign sample_o = sample_q;
  assign cand_o   = cand_q;
  assign tok_o    = '{valid: tok_valid_q, last: tok_last_q, key: tok_key_q,
                      diff: tok_diff_q};

endmodule : swks_cell
`default_nettype wire

// ===== design/swks_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swks_checker : port-level checks of the KS drift detector
// Watches the result channel and the relation between its fields.
// ----------------------------------------------------------------------------
module swks_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  logic                     drift_detected_o,
  input  logic [swks_pkg::KsW-1:0] ks_count_o,
  input  logic                     window_ready_o
);
  import swks_pkg::*;

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // no comparison made: all fields zero
  a_not_ready_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !window_ready_o |-> (ks_count_o == '0) && !drift_detected_o)
    else $error("non-zero result without a full window");

  // drift needs a full window and a count of at least two
  a_drift_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drift_detected_o |-> window_ready_o && (ks_count_o >= KsW'(2)))
    else $error("drift flagged with too small a count");

  // count never exceeds the largest half window
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ks_count_o <= KsW'(MaxHalf))
    else $error("KS count out of range");

endmodule : swks_checker

bind sliding_window_ks_drift_detector_unit swks_checker u_swks_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .drift_detected_o(drift_detected_o),
  .ks_count_o      (ks_count_o),
  .window_ready_o  (window_ready_o)
);
`default_nettype wire

// ===== bench/sliding_window_ks_drift_detector_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_ks_drift_detector_unit_tb : self-checking bench for the KS unit
// A directed table covers reset, the extremes of half_window and of the sample
// word, ties and full separation of the halves. Phases of random samples
// follow, built from level regimes that shift, wide noise and tied levels,
// at several half_window settings. Typed table rows carry their own result;
// all other words are checked against a behavioural model of the window kept here.
// ----------------------------------------------------------------------------
module sliding_window_ks_drift_detector_unit_tb;
  import swks_pkg::*;

  localparam int unsigned Capacity    = DefCapacity;
  localparam int unsigned LatencyMax  = 2 * MaxHalf + Capacity + 8;
  localparam int unsigned QuietLimit  = 8 * LatencyMax;
  localparam int unsigned NumPhases   = 10;
  localparam int unsigned PhaseWords  = 94;
  localparam int unsigned IdlePercent = 28;
  localparam int unsigned CalmPhase   = 3;

  typedef struct packed {
    logic           drift;
    logic [KsW-1:0] ks;
    logic           ready;
  } ks_result_t;

  typedef enum logic [1:0] {RowSample, RowConfig} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [SampleW-1:0] data;
    logic               typed;
    ks_result_t         res;
  } stim_row_t;

  typedef enum logic [1:0] {DriftRegime, WideNoise, TiedLevels} sample_mode_e;

  // directed table: config rows carry half_window in the low bits of data
  localparam int unsigned NumRows = 18;
  localparam stim_row_t DirectedRows [NumRows] = '{
    '{RowSample, 32'h8000_0000, 1'b1, '{1'b0, 7'd0, 1'b0}},
    '{RowSample, 32'h7FFF_FFFF, 1'b1, '{1'b0, 7'd0, 1'b0}},
    '{RowConfig, 32'd1,         1'b0, '{1'b0, 7'd0, 1'b0}},
    '{RowSample, 32'h0000_0000, 1'b1, '{1'b0, 7'd1, 1'b1}},
    '{RowConfig, 32'd2,         1'b0, '{1'b0, 7'd0, 1'b0}},
    '{RowSample, 32'h0001_0000, 1'b0, '{1'b0, 7'd0, 1'b0}},
    '{RowSample, 32'h0001_0000, 1'b0, '{1'b0, 7'd0, 1'b0}},
    '{RowSample, 32'hFFFF_0000, 1'b0, '{1'b0, 7'd0, 1'b0}},
    '{RowSample, 32'hFFFF_0000, 1'b1, '{1'b1, 7'd2, 1'b1}},
    '{RowSample, 32'h0003_0000, 1'b0, '{1'b0, 7'd0, 1'b0}},
    '{RowSample, 32'h0003_0000, 1'b0, '{1'b0, 7'd0, 1'b0}},
    '{RowSample, 32'h0003_0000, 1'b0, '{1'b0, 7'd0, 1'b0}},
    '{RowSample, 32'h0003_0000, 1'b1, '{1'b0, 7'd0, 1'b1}},
    '{RowConfig, 32'd64,        1'b0, '{1'b0, 7'd0, 1'b0}},
    '{RowSample, 32'h5555_5555, 1'b1, '{1'b0, 7'd0, 1'b0}},
    '{RowSample, 32'hAAAA_AAAA, 1'b1, '{1'b0, 7'd0, 1'b0}},
    '{RowSample, 32'hFFFF_FFFF, 1'b1, '{1'b0, 7'd0, 1'b0}},
    '{RowSample, 32'h0000_0000, 1'b1, '{1'b0, 7'd0, 1'b0}}
  };

  // half_window of each random phase, 0 picks one at random
  localparam logic [HwW-1:0] PhaseHalf [NumPhases] = '{
    7'd1, 7'd2, 7'd3, 7'd8, 7'd16, 7'd64, 7'd31, 7'd45, 7'd64, 7'd0
  };

  // DUT ports
  logic                      clk_i             = 1'b0;
  logic                      rst_ni            = 1'b0;
  logic                      cfg_valid_i       = 1'b0;
  logic                      cfg_ready_o;
  logic [HwW-1:0]            cfg_half_window_i = HwReset;
  logic                      in_valid_i        = 1'b0;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] sample_i          = '0;
  logic                      out_valid_o;
  logic                      out_ready_i       = 1'b0;
  logic                      drift_detected_o;
  logic [KsW-1:0]            ks_count_o;
  logic                      window_ready_o;

  // model state and scoreboard
  logic signed [SampleW-1:0] held_samples [$];
  logic [HwW-1:0]            half_window_q = HwReset;
  ks_result_t                ks_results_due [$];
  int unsigned               error_count = 0;
  bit                        calm = 1'b0;

  // random sample source state
  sample_mode_e              seg_mode   = DriftRegime;
  int unsigned               seg_left   = 0;
  logic [SampleW-1:0]        seg_base   = '0;
  logic [SampleW-1:0]        seg_mask   = '0;

  sliding_window_ks_drift_detector_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_half_window_i(cfg_half_window_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drift_detected_o (drift_detected_o),
    .ks_count_o       (ks_count_o),
    .window_ready_o   (window_ready_o)
  );

  always #5 clk_i = ~clk_i;

  // KS count of the newest half_window samples against the half before them
  function automatic ks_result_t ks_window_predict();
    ks_result_t          res;
    int unsigned         r;
    int unsigned         old_base;
    int unsigned         new_base;
    int unsigned         n_old;
    int unsigned         n_new;
    int unsigned         gap;
    int unsigned         best;
    longint unsigned     lhs;
    longint unsigned     rhs;
    logic signed [SampleW-1:0] key;
    res = '0;
    r   = half_window_q;
    if (r == 0 || held_samples.size() < 2 * r) begin
      return res;
    end
    old_base = held_samples.size() - 2 * r;
    new_base = held_samples.size() - r;
    best = 0;
    for (int unsigned i = 0; i < 2 * r; i++) begin
      key   = held_samples[old_base + i];
      n_old = 0;
      n_new = 0;
      for (int unsigned j = 0; j < r; j++) begin
        if (held_samples[old_base + j] <= key) n_old++;
        if (held_samples[new_base + j] <= key) n_new++;
      end
      gap = (n_old > n_new) ? n_old - n_new : n_new - n_old;
      if (gap > best) best = gap;
    end
    lhs       = 64'd10000 * best * best;
    rhs       = 64'd18496 * r;
    res.drift = (lhs > rhs);
    res.ks    = best[KsW-1:0];
    res.ready = 1'b1;
    return res;
  endfunction

  // next random sample: shifting level regimes, wide noise or tied levels
  function automatic logic [SampleW-1:0] next_random_sample();
    int unsigned pick;
    if (seg_left == 0) begin
      pick     = $urandom_range(0, 99);
      seg_left = $urandom_range(4, 90);
      if (pick < 70) begin
        seg_mode = DriftRegime;
        // half the shifts are small so that the count lands near the threshold
        if ($urandom_range(0, 1) == 0) seg_base = $urandom;
        else seg_base = seg_base + ($urandom & seg_mask);
        seg_mask = (32'd1 << $urandom_range(0, 24)) - 32'd1;
      end else if (pick < 85) begin
        seg_mode = WideNoise;
      end else begin
        seg_mode = TiedLevels;
      end
    end
    seg_left--;
    case (seg_mode)
      DriftRegime: begin
        return seg_base + ($urandom & seg_mask);
      end
      WideNoise: begin
        return $urandom;
      end
      default: begin
        return ($urandom_range(0, 6) - 32'd3) << 16;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // lower valid and wait until every expected word has come back
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ks_results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_half_window(input logic [HwW-1:0] hw);
    wait_results_drained();
    cfg_valid_i       <= 1'b1;
    cfg_half_window_i <= hw;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i   <= 1'b0;
    half_window_q = hw;
  endtask

  // offer one sample word; valid stays high on return so back-to-back words
  // never see valid dropped and raised in one step
  task automatic put_sample(input logic [SampleW-1:0] s, input logic typed,
                            input ks_result_t typed_res);
    ks_result_t res;
    while (!calm && $urandom_range(0, 99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    held_samples.push_back(s);
    if (held_samples.size() > Capacity) void'(held_samples.pop_front());
    res = ks_window_predict();
    ks_results_due.push_back(typed ? typed_res : res);
  endtask

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    ks_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (ks_results_due.size() == 0) begin
        $display("%0t: result word with none expected", $realtime);
        error_count++;
      end else begin
        want = ks_results_due.pop_front();
        if (drift_detected_o !== want.drift)
          report_mismatch("drift_detected", drift_detected_o, want.drift);
        if (ks_count_o !== want.ks)
          report_mismatch("ks_count", ks_count_o, want.ks);
        if (window_ready_o !== want.ready)
          report_mismatch("window_ready", window_ready_o, want.ready);
      end
    end
  end

  // watchdog: too long without any word moving on any channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("sliding_window_ks_drift_detector_unit_tb: FAIL");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    logic [HwW-1:0] hw;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int unsigned i = 0; i < NumRows; i++) begin
      if (DirectedRows[i].kind == RowConfig) begin
        write_half_window(DirectedRows[i].data[HwW-1:0]);
      end else begin
        put_sample(DirectedRows[i].data, DirectedRows[i].typed, DirectedRows[i].res);
      end
    end

    // random phases, one half_window setting each; one phase runs without idling
    for (int unsigned p = 0; p < NumPhases; p++) begin
      hw = (PhaseHalf[p] == 0) ? HwW'($urandom_range(1, MaxHalf)) : PhaseHalf[p];
      write_half_window(hw);
      calm = (p == CalmPhase);
      for (int unsigned n = 0; n < PhaseWords; n++) begin
        put_sample(next_random_sample(), 1'b0, '0);
      end
    end
    calm = 1'b0;

    // drain, then watch for stray words
    wait_results_drained();
    repeat (LatencyMax) @(posedge clk_i);
    if (error_count == 0) begin
      $display("sliding_window_ks_drift_detector_unit_tb: PASS");
    end else begin
      $display("sliding_window_ks_drift_detector_unit_tb: FAIL");
    end
    $finish;
  end

endmodule : sliding_window_ks_drift_detector_unit_tb
